/* hw/rtl/cc20_pkg.sv */
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and quarter-round helpers for the chacha20
// keystream pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cc20_pkg;

  typedef logic [31:0]       word_t;
  typedef logic [15:0][31:0] state_t;
  typedef logic [7:0][63:0]  block_t;
  typedef logic [2:0]        widx_t;
  typedef logic [2:0]        cfg_idx_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_KEY0     = 3'd0,
    CFG_KEY1     = 3'd1,
    CFG_KEY2     = 3'd2,
    CFG_KEY3     = 3'd3,
    CFG_NONCE_LO = 3'd4,
    CFG_NONCE_HI = 3'd5
  } cfg_reg_e;

  localparam word_t SIGMA0 = 32'h6170_7865;
  localparam word_t SIGMA1 = 32'h3320_646e;
  localparam word_t SIGMA2 = 32'h7962_2d32;
  localparam word_t SIGMA3 = 32'h6b20_6574;

  localparam widx_t LAST_IDX = 3'd7;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } qr_t;

  function automatic word_t rotl(word_t v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // one half of a quarter round: two add/xor/rotate steps
  function automatic qr_t qr_half(qr_t x, logic second);
    qr_t r;
    r = x;
    r.a = r.a + r.b;
    r.d = second ? rotl(r.d ^ r.a, 8) : rotl(r.d ^ r.a, 16);
    r.c = r.c + r.d;
    r.b = second ? rotl(r.b ^ r.c, 7) : rotl(r.b ^ r.c, 12);
    return r;
  endfunction

  // initial state from key, nonce and counter
  function automatic state_t init_state(logic [63:0] k0, logic [63:0] k1,
                                        logic [63:0] k2, logic [63:0] k3,
                                        logic [63:0] n_lo, logic [31:0] n_hi,
                                        word_t ctr);
    state_t s;
    s[0]  = SIGMA0;
    s[1]  = SIGMA1;
    s[2]  = SIGMA2;
    s[3]  = SIGMA3;
    s[4]  = k0[31:0];
    s[5]  = k0[63:32];
    s[6]  = k1[31:0];
    s[7]  = k1[63:32];
    s[8]  = k2[31:0];
    s[9]  = k2[63:32];
    s[10] = k3[31:0];
    s[11] = k3[63:32];
    s[12] = ctr;
    s[13] = n_lo[31:0];
    s[14] = n_lo[63:32];
    s[15] = n_hi;
    return s;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/cc20_round_stage.sv */
// ----------------------------------------------------------------------------
// cc20_round_stage
// One pipeline stage: half of a column or diagonal round on all four
// quarter-round lanes, registered, with a travelling valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_round_stage #(
  parameter int DIAG   = 0,
  parameter int SECOND = 0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire cc20_pkg::state_t state_i,
  input  wire cc20_pkg::word_t  ctr_i,
  output logic                 valid_o,
  output cc20_pkg::state_t     state_o,
  output cc20_pkg::word_t      ctr_o
);
  import cc20_pkg::*;

  state_t state_d, state_q;
  word_t  ctr_q;
  logic   valid_q;

  // four independent lanes, word selection follows column or diagonal order
  always_comb begin
    qr_t x;
    qr_t r;
    state_d = state_i;
    for (int j = 0; j < 4; j++) begin
      x.a = state_i[j];
      x.b = state_i[4 + ((j + DIAG) & 3)];
      x.c = state_i[8 + ((j + 2 * DIAG) & 3)];
      x.d = state_i[12 + ((j + 3 * DIAG) & 3)];
      r = qr_half(x, (SECOND != 0));
      state_d[j]                          = r.a;
      state_d[4 + ((j + DIAG) & 3)]       = r.b;
      state_d[8 + ((j + 2 * DIAG) & 3)]   = r.c;
      state_d[12 + ((j + 3 * DIAG) & 3)]  = r.d;
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      ctr_q   <= ctr_i;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign ctr_o   = ctr_q;

endmodule

`default_nettype wire

/* hw/rtl/cc20_serializer.sv */
// ----------------------------------------------------------------------------
// cc20_serializer
// Holds one finished 64-byte block and sends it as eight 64-bit beats,
// taking the next block as the last beat leaves, or at once when empty.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_serializer (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire cc20_pkg::block_t in_block_i,
  output logic                 take_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output cc20_pkg::widx_t      word_index_o,
  output logic [63:0]          keystream_word_o,
  output logic                 last_word_o
);
  import cc20_pkg::*;

  logic   valid_q;
  widx_t  idx_q, idx_d;
  block_t blk_q;
  logic   deliver;

  assign deliver = valid_q && !out_stall_i;
  assign take_o  = !valid_q || (deliver && (idx_q == LAST_IDX));
  assign idx_d   = idx_q + 3'd1;

  // beat counter and valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (take_o) begin
      valid_q <= in_valid_i;
      idx_q   <= '0;
    end else if (deliver) begin
      idx_q <= idx_d;
    end
  end

  // block buffer
  always_ff @(posedge clk_i) begin
    if (take_o && in_valid_i) begin
      blk_q <= in_block_i;
    end
  end

  assign out_valid_o      = valid_q;
  assign word_index_o     = idx_q;
  assign keystream_word_o = blk_q[idx_q];
  assign last_word_o      = (idx_q == LAST_IDX);

  // beat index steps by one on each non-final beat
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (deliver && (idx_q != LAST_IDX)) |=> (idx_q == $past(idx_d)))
    else $error("beat index did not advance");

  // a stalled beat keeps its index
  a_idx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_stall_i) |=> (idx_q == $past(idx_q)) && valid_q)
    else $error("stalled beat index moved");

  // an empty load leaves the buffer empty
  a_empty_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && !in_valid_i) |=> !valid_q)
    else $error("buffer valid without a block");

endmodule

`default_nettype wire

/* hw/rtl/chacha20_keystream_block.sv */
// ----------------------------------------------------------------------------
// chacha20_keystream_block
// IETF ChaCha20 block function: pipelined double rounds, final state add,
// and an eight-beat output of the 64-byte keystream block.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+--------------------------
//   cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i / in_stall_o   | block_counter_i
//   out     | out       | out_valid_o / out_stall_i | word_index_o,
//           |           |                           | keystream_word_o, last_word_o
//
// A counter passes the round stages and the serializer buffer before its first
// beat is offered; each stage holds half a round of all four quarter-round
// lanes. Sustained rate is set by the eight output beats of each block: the
// pipeline buffers counters and advances only as the serializer takes a block.
// A stalled output freezes the whole round pipeline; nothing is dropped.
// Reset clears valid bits, the beat counter and the key and nonce registers.
// ----------------------------------------------------------------------------
`default_nettype none

module chacha20_keystream_block #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire cc20_pkg::cfg_idx_t  cfg_index_i,
  input  wire logic [63:0]         cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [31:0]         block_counter_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [2:0]               word_index_o,
  output logic [63:0]              keystream_word_o,
  output logic                     last_word_o
);
  import cc20_pkg::*;

  localparam int NSTAGE = 4 * DOUBLE_ROUNDS;

  logic [63:0] key0_q, key1_q, key2_q, key3_q, nonce_lo_q;
  logic [31:0] nonce_hi_q;

  logic   en;
  logic   take;
  logic   s_valid [NSTAGE+1];
  state_t s_state [NSTAGE+1];
  word_t  s_ctr   [NSTAGE+1];
  state_t init_last;
  block_t blk;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q     <= '0;
      key1_q     <= '0;
      key2_q     <= '0;
      key3_q     <= '0;
      nonce_lo_q <= '0;
      nonce_hi_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_KEY0:     key0_q     <= cfg_data_i;
        CFG_KEY1:     key1_q     <= cfg_data_i;
        CFG_KEY2:     key2_q     <= cfg_data_i;
        CFG_KEY3:     key3_q     <= cfg_data_i;
        CFG_NONCE_LO: nonce_lo_q <= cfg_data_i;
        CFG_NONCE_HI: nonce_hi_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves when the serializer can take its last stage
  assign en         = take;
  assign in_stall_o = !en;

  // pipeline entry
  assign s_valid[0] = in_valid_i;
  assign s_ctr[0]   = block_counter_i;
  assign s_state[0] = init_state(key0_q, key1_q, key2_q, key3_q,
                                 nonce_lo_q, nonce_hi_q, block_counter_i);

  // round stages: column first half, column second half, diagonal halves
  for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
    cc20_round_stage #(
      .DIAG   ((k / 2) % 2),
      .SECOND (k % 2)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (s_valid[k]),
      .state_i (s_state[k]),
      .ctr_i   (s_ctr[k]),
      .valid_o (s_valid[k+1]),
      .state_o (s_state[k+1]),
      .ctr_o   (s_ctr[k+1])
    );
  end

  // final add of the initial state, rebuilt from the carried counter
  assign init_last = init_state(key0_q, key1_q, key2_q, key3_q,
                                nonce_lo_q, nonce_hi_q, s_ctr[NSTAGE]);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      blk[i][31:0]  = s_state[NSTAGE][2*i]   + init_last[2*i];
      blk[i][63:32] = s_state[NSTAGE][2*i+1] + init_last[2*i+1];
    end
  end

  cc20_serializer u_ser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_valid[NSTAGE]),
    .in_block_i       (blk),
    .take_o           (take),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .word_index_o     (word_index_o),
    .keystream_word_o (keystream_word_o),
    .last_word_o      (last_word_o)
  );

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chacha20 keystream block. A clocked driver
// feeds block counters from a backlog queue; a local block-function model
// predicts the eight 64-bit beats of each block from its own copy of the key
// and nonce registers, and a clocked monitor compares every output beat.
// Key and nonce settings change only while the block is drained: zero,
// the standard test key, all ones, and random values. Both channels idle at
// random, with one long output hold that backs up the round pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import cc20_pkg::*;

  localparam int DBL_ROUNDS   = 10;
  localparam int PIPE_LATENCY = 4 * DBL_ROUNDS + 1;
  localparam int LONG_HOLD    = 400;
  localparam int STUCK_LIMIT  = 3000;
  localparam int BEATS        = 8;

  // indexes outside the register map, writes there must be dropped
  localparam cfg_idx_t CFG_SPARE6 = 3'd6;
  localparam cfg_idx_t CFG_SPARE7 = 3'd7;

  typedef logic [15:0][31:0] lane_vec_t;

  typedef struct packed {
    logic [2:0]  widx;
    logic [63:0] word;
    logic        last;
  } ks_beat_t;

  // dut ports
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  cfg_idx_t    cfg_index_i     = '0;
  logic [63:0] cfg_data_i      = '0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [31:0] block_counter_i = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [2:0]  word_index_o;
  logic [63:0] keystream_word_o;
  logic        last_word_o;

  // local copy of the key and nonce registers
  logic [63:0] key_cfg [4] = '{default: '0};
  logic [63:0] nonce_lo_cfg = '0;
  logic [31:0] nonce_hi_cfg = '0;

  // queues and run bookkeeping
  logic [31:0] counter_backlog [$];
  ks_beat_t    ks_expected [$];
  int          gap_left     = 0;
  int          stall_left   = 0;
  int          hold_left    = 0;
  logic        hold_req     = 1'b0;
  logic        hold_taken   = 1'b0;
  logic        no_idle      = 1'b0;
  int          stuck_cycles = 0;
  int          err_count    = 0;
  int          n_counters   = 0;
  int          n_beats      = 0;
  int          n_writes     = 0;
  int          n_settings   = 0;

  chacha20_keystream_block #(
    .DOUBLE_ROUNDS(DBL_ROUNDS)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .block_counter_i (block_counter_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .word_index_o    (word_index_o),
    .keystream_word_o(keystream_word_o),
    .last_word_o     (last_word_o)
  );

  // 20-unit clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // left rotate through a doubled word
  function automatic logic [31:0] rol32(logic [31:0] v, int n);
    logic [63:0] twice;
    twice = {v, v} >> (32 - n);
    return twice[31:0];
  endfunction

  // one quarter round on lanes a, b, c, d
  function automatic lane_vec_t mix_lanes(lane_vec_t s, int a, int b, int c, int d);
    s[a] = s[a] + s[b];
    s[d] = rol32(s[d] ^ s[a], 16);
    s[c] = s[c] + s[d];
    s[b] = rol32(s[b] ^ s[c], 12);
    s[a] = s[a] + s[b];
    s[d] = rol32(s[d] ^ s[a], 8);
    s[c] = s[c] + s[d];
    s[b] = rol32(s[b] ^ s[c], 7);
    return s;
  endfunction

  // full block function for one counter under the current key and nonce
  function automatic lane_vec_t keystream_block(logic [31:0] ctr);
    lane_vec_t start_st;
    lane_vec_t x;
    start_st[0] = SIGMA0;
    start_st[1] = SIGMA1;
    start_st[2] = SIGMA2;
    start_st[3] = SIGMA3;
    for (int k = 0; k < 4; k++) begin
      start_st[4 + 2 * k] = key_cfg[k][31:0];
      start_st[5 + 2 * k] = key_cfg[k][63:32];
    end
    start_st[12] = ctr;
    start_st[13] = nonce_lo_cfg[31:0];
    start_st[14] = nonce_lo_cfg[63:32];
    start_st[15] = nonce_hi_cfg;
    x = start_st;
    for (int r = 0; r < DBL_ROUNDS; r++) begin
      x = mix_lanes(x, 0, 4, 8, 12);
      x = mix_lanes(x, 1, 5, 9, 13);
      x = mix_lanes(x, 2, 6, 10, 14);
      x = mix_lanes(x, 3, 7, 11, 15);
      x = mix_lanes(x, 0, 5, 10, 15);
      x = mix_lanes(x, 1, 6, 11, 12);
      x = mix_lanes(x, 2, 7, 8, 13);
      x = mix_lanes(x, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) begin
      x[i] = x[i] + start_st[i];
    end
    return x;
  endfunction

  // queue the eight beats expected for one accepted counter
  task automatic predict_keystream(logic [31:0] ctr);
    lane_vec_t blk;
    ks_beat_t  beat;
    blk = keystream_block(ctr);
    for (int i = 0; i < BEATS; i++) begin
      beat.widx = 3'(i);
      beat.word = {blk[2 * i + 1], blk[2 * i]};
      beat.last = (beat.widx == LAST_IDX);
      ks_expected.push_back(beat);
    end
  endtask

  function automatic int sender_gap();
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic int receiver_wait();
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // counter driver: counters from the backlog, random gap after each
  always @(posedge clk_i) begin : counter_driver
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_keystream(block_counter_i);
        n_counters++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (counter_backlog.size() != 0) begin
          in_valid_i      <= 1'b1;
          block_counter_i <= counter_backlog.pop_front();
          gap_left        <= sender_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output side stall: per-beat waits, plus one long hold on request
  always @(posedge clk_i) begin : beat_receiver
    int wait_n;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      hold_left   <= 0;
      hold_taken  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= (hold_left != 1);
    end else if (hold_req && !hold_taken) begin
      hold_taken  <= 1'b1;
      hold_left   <= LONG_HOLD;
      out_stall_i <= 1'b1;
    end else if (out_valid_o && !out_stall_i) begin
      wait_n      = receiver_wait();
      stall_left  <= wait_n;
      out_stall_i <= (wait_n != 0);
    end else if (stall_left > 1) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      stall_left  <= 0;
      out_stall_i <= 1'b0;
    end
  end

  // beat monitor: compare each accepted beat with the oldest expectation
  always @(posedge clk_i) begin : beat_monitor
    ks_beat_t exp_beat;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_beats++;
      if (ks_expected.size() == 0) begin
        err_count++;
        $display("%0t unexpected beat: word_index %0d keystream_word %h last_word %b",
                 $time, word_index_o, keystream_word_o, last_word_o);
      end else begin
        exp_beat = ks_expected.pop_front();
        if (word_index_o !== exp_beat.widx) begin
          err_count++;
          $display("%0t word_index mismatch: expected %0d, actual %0d",
                   $time, exp_beat.widx, word_index_o);
        end
        if (keystream_word_o !== exp_beat.word) begin
          err_count++;
          $display("%0t keystream_word mismatch (word %0d): expected %h, actual %h",
                   $time, exp_beat.widx, exp_beat.word, keystream_word_o);
        end
        if (last_word_o !== exp_beat.last) begin
          err_count++;
          $display("%0t last_word mismatch (word %0d): expected %b, actual %b",
                   $time, exp_beat.widx, exp_beat.last, last_word_o);
        end
      end
    end
  end

  // watchdog on cycles without any accepted counter, beat or register write
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t timeout: no beat accepted for %0d cycles, %0d beats outstanding",
                 $time, stuck_cycles, ks_expected.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // one register write, mirrored into the local copy when it lands
  task automatic write_reg(cfg_idx_t idx, logic [63:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    n_writes++;
    case (idx)
      CFG_KEY0:     key_cfg[0]   = data;
      CFG_KEY1:     key_cfg[1]   = data;
      CFG_KEY2:     key_cfg[2]   = data;
      CFG_KEY3:     key_cfg[3]   = data;
      CFG_NONCE_LO: nonce_lo_cfg = data;
      CFG_NONCE_HI: nonce_hi_cfg = data[31:0];
      default: ;
    endcase
  endtask

  // full key and nonce setting, with writes to both spare indexes
  task automatic load_settings(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                               logic [63:0] k3, logic [63:0] n_lo, logic [63:0] n_hi);
    write_reg(CFG_SPARE6, {$urandom, $urandom});
    write_reg(CFG_KEY0, k0);
    write_reg(CFG_KEY1, k1);
    write_reg(CFG_KEY2, k2);
    write_reg(CFG_KEY3, k3);
    write_reg(CFG_NONCE_LO, n_lo);
    write_reg(CFG_NONCE_HI, n_hi);
    write_reg(CFG_SPARE7, {$urandom, $urandom});
    n_settings++;
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand_reg_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] rand_counter();
    case ($urandom_range(0, 5))
      0:       return 32'($urandom_range(0, 15));
      1:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // wait until every counter is in and every beat is out
  task automatic drain();
    while (counter_backlog.size() != 0 || in_valid_i || ks_expected.size() != 0)
      @(negedge clk_i);
    repeat (PIPE_LATENCY + 4) @(negedge clk_i);
  endtask

  // stimulus sequence
  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // registers at their reset value of zero
    n_settings = 1;
    counter_backlog = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF};
    drain();

    // standard test key 00..1f, nonce 000000090000004a00000000; wide
    // data on the nonce high word must lose its upper half
    load_settings(64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908,
                  64'h1716_1514_1312_1110, 64'h1F1E_1D1C_1B1A_1918,
                  64'h4A00_0000_0900_0000, 64'hDEAD_BEEF_0000_0000);
    counter_backlog = '{32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF,
                        32'h5555_5555, 32'hAAAA_AAAA};
    drain();

    // every key and nonce bit set
    load_settings('1, '1, '1, '1, '1, '1);
    counter_backlog = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom, $urandom};
    drain();

    // long output hold while counters arrive back to back
    load_settings(rand_reg_value(), rand_reg_value(), rand_reg_value(),
                  rand_reg_value(), rand_reg_value(), rand_reg_value());
    no_idle  = 1'b1;
    hold_req = 1'b1;
    repeat (45) counter_backlog.push_back(rand_counter());
    drain();
    no_idle = 1'b0;

    // random settings with random idling on both sides
    for (int ph = 0; ph < 4; ph++) begin
      load_settings(rand_reg_value(), rand_reg_value(), rand_reg_value(),
                    rand_reg_value(), rand_reg_value(), rand_reg_value());
      repeat (12) counter_backlog.push_back(rand_counter());
      drain();
    end

    $display("run covered %0d block counters under %0d key/nonce settings, %0d register writes",
             n_counters, n_settings, n_writes);
    $display("%0d keystream beats compared, %0d mismatches", n_beats, err_count);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
